FILE: hdl/assert_macros.svh
// Assertion helpers used by the RTL file that checks itself.
// Every macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SRAT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define SRAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/srat_pkg.sv
`default_nettype none
package srat_pkg;

    localparam int MAX_REQUESTS = 16;
    localparam int MAX_SUBS     = 64;
    localparam int REQ_AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int SUB_AW = (MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1;
    localparam int IDX_W  = (REQ_AW > SUB_AW) ? REQ_AW : SUB_AW;
    localparam int CNT_W  = IDX_W + 1;

    localparam int TIMEOUT_W = 16;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd20;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Register index taken from paddr[2]
    localparam logic REG_TIMEOUT = 1'b0;

    // Mode codes on the request channel
    localparam logic [2:0] MODE_REGISTER = 3'd0;
    localparam logic [2:0] MODE_ACK      = 3'd1;
    localparam logic [2:0] MODE_DEL_REQ  = 3'd2;
    localparam logic [2:0] MODE_DEL_SUB  = 3'd3;
    localparam logic [2:0] MODE_LOOKUP   = 3'd4;
    localparam logic [2:0] MODE_SWEEP    = 3'd5;

    // Result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef enum logic [2:0] {
        OP_REGISTER,
        OP_ACK,
        OP_DEL_REQ,
        OP_DEL_SUB,
        OP_LOOKUP,
        OP_SWEEP,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] req_id;
        logic [31:0] sub_id;
        logic [31:0] opcode;
        logic [31:0] now;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_chan_t;

    typedef struct packed {
        logic busy;
    } back_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUB_SCAN,
        ST_REQ_SCAN,
        ST_ACK_SCAN,
        ST_REQ_READ,
        ST_REQ_WAIT,
        ST_EMIT,
        ST_RM_SCAN,
        ST_EXP_SCAN,
        ST_MIN_SCAN
    } state_t;

endpackage
`default_nettype wire

FILE: hdl/srat_in_if.sv
`default_nettype none
interface srat_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [31:0] req_id;
    logic [31:0] sub_id;
    logic [31:0] opcode;
    logic [31:0] now;

    modport source (output valid, mode, req_id, sub_id, opcode, now, input ready);
    modport sink (input valid, mode, req_id, sub_id, opcode, now, output ready);
endinterface
`default_nettype wire

FILE: hdl/srat_out_if.sv
`default_nettype none
interface srat_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] request_id;
    logic        finished;
    logic        last;

    modport source (output valid, status, request_id, finished, last, input ready);
    modport sink (input valid, status, request_id, finished, last, output ready);
endinterface
`default_nettype wire

FILE: hdl/split_request_ack_tracker_top.sv
`default_nettype none
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   mode, req_id, sub_id, opcode, now
// out_ch    out  valid/ready   status, request_id, finished, last
// apb       in   psel/penable  paddr, pwdata -> prdata (timeout_seconds at 0x0)
//
// A two-entry queue takes requests while the tracker works on an earlier one.
// Each request walks the tables one entry a cycle through the single read port
// of each table: register scans subs then requests, lookup scans subs, ack and
// delete by sub scan subs twice, delete by request scans requests then subs, and
// sweep scans requests, then for each removed request scans requests and subs.
// A stalled result holds the engine.
// Reset clears all valid bits at once; no clearing pass is needed.
`include "assert_macros.svh"
module split_request_ack_tracker_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    srat_in_if.sink          in_ch,
    srat_out_if.source       out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [srat_pkg::TIMEOUT_W-1:0] timeout_reg, timeout_next;
    srat_pkg::cmd_chan_t            cmd_chan;
    srat_pkg::back_stat_t           back_stat;
    logic                           cmd_ready;
    logic                           cfg_write;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == srat_pkg::REG_TIMEOUT);
    assign prdata    = (paddr[2] == srat_pkg::REG_TIMEOUT) ? {16'd0, timeout_reg} : '0;

    always_comb
    begin
        timeout_next = timeout_reg;
        if (cfg_write)
        begin
            timeout_next = pwdata[srat_pkg::TIMEOUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= srat_pkg::TIMEOUT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    srat_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd_out   (cmd_chan),
        .cmd_ready (cmd_ready)
    );

    srat_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_in    (cmd_chan),
        .cmd_ready (cmd_ready),
        .timeout   (timeout_reg),
        .stat      (back_stat),
        .out_ch    (out_ch)
    );

    `SRAT_ASSERT_NEXT(a_handoff_busy, cmd_chan.valid && cmd_ready, back_stat.busy, "request taken but engine idle")
    `SRAT_ASSERT_IMP(a_idle_ready, !back_stat.busy, cmd_ready, "idle engine refuses requests")
    `SRAT_ASSERT_NEXT(a_cfg_write, cfg_write, timeout_reg == $past(pwdata[15:0]), "timeout write lost")

endmodule
`default_nettype wire

FILE: hdl/srat_front.sv
`default_nettype none
module srat_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    srat_in_if.sink                   in_ch,
    output srat_pkg::cmd_chan_t       cmd_out,
    input  wire logic                 cmd_ready
);

    srat_pkg::cmd_t                   q_mem_reg [srat_pkg::QUEUE_DEPTH];
    logic [srat_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [srat_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [srat_pkg::QPTR_W:0]        count_reg, count_next;
    srat_pkg::cmd_t                   in_cmd;
    logic                             push, pop;

    // Classify the request by mode
    always_comb
    begin
        in_cmd.req_id = in_ch.req_id;
        in_cmd.sub_id = in_ch.sub_id;
        in_cmd.opcode = in_ch.opcode;
        in_cmd.now    = in_ch.now;
        unique case (in_ch.mode)
            srat_pkg::MODE_REGISTER: in_cmd.op = srat_pkg::OP_REGISTER;
            srat_pkg::MODE_ACK:      in_cmd.op = srat_pkg::OP_ACK;
            srat_pkg::MODE_DEL_REQ:  in_cmd.op = srat_pkg::OP_DEL_REQ;
            srat_pkg::MODE_DEL_SUB:  in_cmd.op = srat_pkg::OP_DEL_SUB;
            srat_pkg::MODE_LOOKUP:   in_cmd.op = srat_pkg::OP_LOOKUP;
            srat_pkg::MODE_SWEEP:    in_cmd.op = srat_pkg::OP_SWEEP;
            default:                 in_cmd.op = srat_pkg::OP_BAD;
        endcase
    end

    // Queue handshake
    assign in_ch.ready   = (count_reg != (srat_pkg::QPTR_W+1)'(srat_pkg::QUEUE_DEPTH));
    assign push          = in_ch.valid && in_ch.ready;
    assign cmd_out.valid = (count_reg != '0);
    assign cmd_out.cmd   = q_mem_reg[rd_ptr_reg];
    assign pop           = cmd_out.valid && cmd_ready;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == srat_pkg::QPTR_W'(srat_pkg::QUEUE_DEPTH-1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == srat_pkg::QPTR_W'(srat_pkg::QUEUE_DEPTH-1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued requests
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/srat_back.sv
`default_nettype none
module srat_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire srat_pkg::cmd_chan_t            cmd_in,
    output logic                                cmd_ready,
    input  wire logic [srat_pkg::TIMEOUT_W-1:0] timeout,
    output srat_pkg::back_stat_t                stat,
    srat_out_if.source                          out_ch
);

    localparam int NR = srat_pkg::MAX_REQUESTS;
    localparam int NS = srat_pkg::MAX_SUBS;
    localparam int RW = srat_pkg::REQ_AW;
    localparam int SW = srat_pkg::SUB_AW;
    localparam int IW = srat_pkg::IDX_W;
    localparam int CW = srat_pkg::CNT_W;
    localparam logic [CW-1:0] SUB_LEN   = CW'(NS);
    localparam logic [CW-1:0] REQ_LEN   = CW'(NR);
    localparam logic [RW:0]   REQ_LIMIT = (RW+1)'(NR);

    // Tables
    logic [31:0]   sub_ident_mem [NS];
    logic [RW-1:0] sub_owner_mem [NS];
    logic [31:0]   req_ident_mem [NR];
    logic [31:0]   req_code_mem  [NR];
    logic [31:0]   req_start_mem [NR];
    logic [31:0]   sub_ident_rd_reg;
    logic [RW-1:0] sub_owner_rd_reg;
    logic [31:0]   req_ident_rd_reg;
    logic [31:0]   req_start_rd_reg;

    logic [NS-1:0] sub_valid_reg, sub_valid_next;
    logic [NS-1:0] sub_acked_reg, sub_acked_next;
    logic [NR-1:0] req_valid_reg, req_valid_next;
    logic [NR-1:0] expired_reg, expired_next;

    srat_pkg::state_t state_reg, state_next;
    srat_pkg::state_t after_reg, after_next;
    srat_pkg::cmd_t   cmd_reg, cmd_next;

    logic [CW-1:0] scan_cnt_reg, scan_cnt_next;
    logic [IW-1:0] rd_idx_reg;
    logic          rd_live_reg, rd_live_next;

    logic          s_found_reg, s_found_next;
    logic [SW-1:0] s_idx_reg, s_idx_next;
    logic [RW-1:0] s_owner_reg, s_owner_next;
    logic          fs_found_reg, fs_found_next;
    logic [SW-1:0] fs_idx_reg, fs_idx_next;
    logic          r_found_reg, r_found_next;
    logic [RW-1:0] r_idx_reg, r_idx_next;
    logic          fr_found_reg, fr_found_next;
    logic [RW-1:0] fr_idx_reg, fr_idx_next;
    logic [RW-1:0] slot_reg, slot_next;
    logic          any_reg, any_next;
    logic          all_reg, all_next;
    logic          best_found_reg, best_found_next;
    logic [RW-1:0] best_idx_reg, best_idx_next;
    logic [31:0]   best_ident_reg, best_ident_next;
    logic          sweep_more_reg, sweep_more_next;

    logic [1:0]    res_status_reg, res_status_next;
    logic [31:0]   res_rid_reg, res_rid_next;
    logic          res_fin_reg, res_fin_next;
    logic          res_last_reg, res_last_next;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_status_reg;
    logic [31:0]   out_rid_reg;
    logic          out_fin_reg;
    logic          out_last_reg;

    logic          sub_scan, req_scan, issue, scan_done, push;
    logic [CW-1:0] scan_len;
    logic [SW-1:0] rd_sidx;
    logic [RW-1:0] rd_ridx;
    logic [RW-1:0] req_raddr;
    logic          sub_we;
    logic [SW-1:0] sub_waddr;
    logic [RW-1:0] sub_wowner;
    logic          req_we;
    logic [RW-1:0] req_waddr;
    logic [NR-1:0] remaining;
    logic [RW-1:0] r_use;
    logic [SW-1:0] s_use;

    assign rd_sidx   = rd_idx_reg[SW-1:0];
    assign rd_ridx   = rd_idx_reg[RW-1:0];
    assign cmd_ready = (state_reg == srat_pkg::ST_IDLE);
    assign stat.busy = (state_reg != srat_pkg::ST_IDLE);
    assign push      = (state_reg == srat_pkg::ST_EMIT) && (!out_valid_reg || out_ch.ready);
    assign req_raddr = (state_reg == srat_pkg::ST_REQ_READ) ? slot_reg : scan_cnt_reg[RW-1:0];
    assign remaining = expired_reg & ~({{(NR-1){1'b0}}, 1'b1} << best_idx_reg);

    // Scan sequencing: address goes out one cycle, data comes back the next
    always_comb
    begin
        sub_scan  = (state_reg == srat_pkg::ST_SUB_SCAN) || (state_reg == srat_pkg::ST_ACK_SCAN) ||
                    (state_reg == srat_pkg::ST_RM_SCAN);
        req_scan  = (state_reg == srat_pkg::ST_REQ_SCAN) || (state_reg == srat_pkg::ST_EXP_SCAN) ||
                    (state_reg == srat_pkg::ST_MIN_SCAN);
        scan_len  = sub_scan ? SUB_LEN : REQ_LEN;
        issue     = (sub_scan || req_scan) && (scan_cnt_reg < scan_len);
        scan_done = (sub_scan || req_scan) && (scan_cnt_reg == scan_len) && !rd_live_reg;
    end

    // Next state and table updates
    always_comb
    begin
        state_next      = state_reg;
        after_next      = after_reg;
        cmd_next        = cmd_reg;
        sub_valid_next  = sub_valid_reg;
        sub_acked_next  = sub_acked_reg;
        req_valid_next  = req_valid_reg;
        expired_next    = expired_reg;
        s_found_next    = s_found_reg;
        s_idx_next      = s_idx_reg;
        s_owner_next    = s_owner_reg;
        fs_found_next   = fs_found_reg;
        fs_idx_next     = fs_idx_reg;
        r_found_next    = r_found_reg;
        r_idx_next      = r_idx_reg;
        fr_found_next   = fr_found_reg;
        fr_idx_next     = fr_idx_reg;
        slot_next       = slot_reg;
        any_next        = any_reg;
        all_next        = all_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_ident_next = best_ident_reg;
        sweep_more_next = sweep_more_reg;
        res_status_next = res_status_reg;
        res_rid_next    = res_rid_reg;
        res_fin_next    = res_fin_reg;
        res_last_next   = res_last_reg;
        sub_we          = 1'b0;
        sub_waddr       = s_idx_reg;
        sub_wowner      = r_idx_reg;
        req_we          = 1'b0;
        req_waddr       = fr_idx_reg;
        r_use           = r_found_reg ? r_idx_reg : fr_idx_reg;
        s_use           = s_found_reg ? s_idx_reg : fs_idx_reg;

        unique case (state_reg)
            srat_pkg::ST_IDLE:
            begin
                if (cmd_in.valid)
                begin
                    cmd_next        = cmd_in.cmd;
                    s_found_next    = 1'b0;
                    fs_found_next   = 1'b0;
                    r_found_next    = 1'b0;
                    fr_found_next   = 1'b0;
                    best_found_next = 1'b0;
                    sweep_more_next = 1'b0;
                    after_next      = srat_pkg::ST_IDLE;
                    unique case (cmd_in.cmd.op) inside
                        srat_pkg::OP_REGISTER, srat_pkg::OP_ACK,
                        srat_pkg::OP_DEL_SUB, srat_pkg::OP_LOOKUP:
                            state_next = srat_pkg::ST_SUB_SCAN;
                        srat_pkg::OP_DEL_REQ:
                            state_next = srat_pkg::ST_REQ_SCAN;
                        srat_pkg::OP_SWEEP:
                            state_next = srat_pkg::ST_EXP_SCAN;
                        default:
                        begin
                            res_status_next = srat_pkg::STATUS_MISS;
                            res_rid_next    = '0;
                            res_fin_next    = 1'b0;
                            res_last_next   = 1'b1;
                            state_next      = srat_pkg::ST_EMIT;
                        end
                    endcase
                end
            end

            srat_pkg::ST_SUB_SCAN:
            begin
                // Find the sub and the first free sub slot
                if (rd_live_reg)
                begin
                    if (sub_valid_reg[rd_sidx] && (sub_ident_rd_reg == cmd_reg.sub_id) &&
                        ({1'b0, sub_owner_rd_reg} < REQ_LIMIT) && !s_found_reg)
                    begin
                        s_found_next = 1'b1;
                        s_idx_next   = rd_sidx;
                        s_owner_next = sub_owner_rd_reg;
                    end
                    if (!sub_valid_reg[rd_sidx] && !fs_found_reg)
                    begin
                        fs_found_next = 1'b1;
                        fs_idx_next   = rd_sidx;
                    end
                end
                if (scan_done)
                begin
                    res_fin_next  = 1'b0;
                    res_last_next = 1'b1;
                    if (cmd_reg.op == srat_pkg::OP_REGISTER)
                    begin
                        state_next = srat_pkg::ST_REQ_SCAN;
                    end
                    else if (!s_found_reg || !req_valid_reg[s_owner_reg])
                    begin
                        res_status_next = srat_pkg::STATUS_MISS;
                        res_rid_next    = '0;
                        state_next      = srat_pkg::ST_EMIT;
                    end
                    else
                    begin
                        slot_next = s_owner_reg;
                        if (cmd_reg.op == srat_pkg::OP_ACK)
                        begin
                            sub_acked_next[s_idx_reg] = 1'b1;
                            any_next   = 1'b0;
                            all_next   = 1'b1;
                            state_next = srat_pkg::ST_ACK_SCAN;
                        end
                        else
                        begin
                            state_next = srat_pkg::ST_REQ_READ;
                        end
                    end
                end
            end

            srat_pkg::ST_REQ_SCAN:
            begin
                // Find the request and the first free request slot
                if (rd_live_reg)
                begin
                    if (req_valid_reg[rd_ridx] && (req_ident_rd_reg == cmd_reg.req_id) &&
                        !r_found_reg)
                    begin
                        r_found_next = 1'b1;
                        r_idx_next   = rd_ridx;
                    end
                    if (!req_valid_reg[rd_ridx] && !fr_found_reg)
                    begin
                        fr_found_next = 1'b1;
                        fr_idx_next   = rd_ridx;
                    end
                end
                if (scan_done)
                begin
                    res_fin_next  = 1'b0;
                    res_last_next = 1'b1;
                    state_next    = srat_pkg::ST_EMIT;
                    if (cmd_reg.op == srat_pkg::OP_REGISTER)
                    begin
                        if ((!r_found_reg && !fr_found_reg) || (!s_found_reg && !fs_found_reg))
                        begin
                            res_status_next = srat_pkg::STATUS_FULL;
                            res_rid_next    = '0;
                        end
                        else
                        begin
                            if (!r_found_reg)
                            begin
                                req_we                     = 1'b1;
                                req_waddr                  = fr_idx_reg;
                                req_valid_next[fr_idx_reg] = 1'b1;
                            end
                            sub_we                = 1'b1;
                            sub_waddr             = s_use;
                            sub_wowner            = r_use;
                            sub_valid_next[s_use] = 1'b1;
                            sub_acked_next[s_use] = 1'b0;
                            res_status_next       = srat_pkg::STATUS_OK;
                            res_rid_next          = cmd_reg.req_id;
                        end
                    end
                    else if (!r_found_reg)
                    begin
                        res_status_next = srat_pkg::STATUS_MISS;
                        res_rid_next    = '0;
                    end
                    else
                    begin
                        req_valid_next[r_idx_reg] = 1'b0;
                        slot_next                 = r_idx_reg;
                        res_status_next           = srat_pkg::STATUS_OK;
                        res_rid_next              = cmd_reg.req_id;
                        after_next                = srat_pkg::ST_RM_SCAN;
                    end
                end
            end

            srat_pkg::ST_ACK_SCAN:
            begin
                // Check every sub of the owner for its ack
                if (rd_live_reg && sub_valid_reg[rd_sidx] && (sub_owner_rd_reg == slot_reg))
                begin
                    any_next = 1'b1;
                    if (!sub_acked_reg[rd_sidx])
                    begin
                        all_next = 1'b0;
                    end
                end
                if (scan_done)
                begin
                    state_next = srat_pkg::ST_REQ_READ;
                end
            end

            srat_pkg::ST_REQ_READ:
            begin
                state_next = srat_pkg::ST_REQ_WAIT;
            end

            srat_pkg::ST_REQ_WAIT:
            begin
                res_status_next = srat_pkg::STATUS_OK;
                res_rid_next    = req_ident_rd_reg;
                res_fin_next    = (cmd_reg.op == srat_pkg::OP_ACK) && any_reg && all_reg;
                res_last_next   = 1'b1;
                if (cmd_reg.op == srat_pkg::OP_DEL_SUB)
                begin
                    req_valid_next[slot_reg] = 1'b0;
                    after_next               = srat_pkg::ST_RM_SCAN;
                end
                state_next = srat_pkg::ST_EMIT;
            end

            srat_pkg::ST_EMIT:
            begin
                if (push)
                begin
                    state_next = after_reg;
                end
            end

            srat_pkg::ST_RM_SCAN:
            begin
                // Drop every sub owned by the removed request
                if (rd_live_reg && sub_valid_reg[rd_sidx] && (sub_owner_rd_reg == slot_reg))
                begin
                    sub_valid_next[rd_sidx] = 1'b0;
                    sub_acked_next[rd_sidx] = 1'b0;
                end
                if (scan_done)
                begin
                    best_found_next = 1'b0;
                    state_next      = sweep_more_reg ? srat_pkg::ST_MIN_SCAN : srat_pkg::ST_IDLE;
                end
            end

            srat_pkg::ST_EXP_SCAN:
            begin
                // Mark requests past the timeout
                if (rd_live_reg)
                begin
                    expired_next[rd_ridx] = req_valid_reg[rd_ridx] &&
                        ((cmd_reg.now - req_start_rd_reg) > {16'd0, timeout});
                end
                if (scan_done)
                begin
                    if (expired_reg == '0)
                    begin
                        res_status_next = srat_pkg::STATUS_MISS;
                        res_rid_next    = '0;
                        res_fin_next    = 1'b0;
                        res_last_next   = 1'b1;
                        state_next      = srat_pkg::ST_EMIT;
                    end
                    else
                    begin
                        best_found_next = 1'b0;
                        state_next      = srat_pkg::ST_MIN_SCAN;
                    end
                end
            end

            srat_pkg::ST_MIN_SCAN:
            begin
                // Pick the expired request with the lowest id
                if (rd_live_reg && expired_reg[rd_ridx] &&
                    (!best_found_reg || (req_ident_rd_reg < best_ident_reg)))
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = rd_ridx;
                    best_ident_next = req_ident_rd_reg;
                end
                if (scan_done)
                begin
                    expired_next                 = remaining;
                    req_valid_next[best_idx_reg] = 1'b0;
                    slot_next                    = best_idx_reg;
                    sweep_more_next              = (remaining != '0);
                    res_status_next              = srat_pkg::STATUS_OK;
                    res_rid_next                 = best_ident_reg;
                    res_fin_next                 = 1'b0;
                    res_last_next                = (remaining == '0);
                    after_next                   = srat_pkg::ST_RM_SCAN;
                    state_next                   = srat_pkg::ST_EMIT;
                end
            end

            default:
            begin
                state_next = srat_pkg::ST_IDLE;
            end
        endcase

        // Restart the scan counter on every state change
        if (state_next != state_reg)
        begin
            scan_cnt_next = '0;
            rd_live_next  = 1'b0;
        end
        else
        begin
            scan_cnt_next = scan_cnt_reg + CW'(issue);
            rd_live_next  = issue;
        end
    end

    // Hold the result until taken
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ch.ready;
        if (push)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.status     = out_status_reg;
    assign out_ch.request_id = out_rid_reg;
    assign out_ch.finished   = out_fin_reg;
    assign out_ch.last       = out_last_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= srat_pkg::ST_IDLE;
            after_reg      <= srat_pkg::ST_IDLE;
            scan_cnt_reg   <= '0;
            rd_live_reg    <= 1'b0;
            sub_valid_reg  <= '0;
            sub_acked_reg  <= '0;
            req_valid_reg  <= '0;
            expired_reg    <= '0;
            s_found_reg    <= 1'b0;
            fs_found_reg   <= 1'b0;
            r_found_reg    <= 1'b0;
            fr_found_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            sweep_more_reg <= 1'b0;
            any_reg        <= 1'b0;
            all_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            after_reg      <= after_next;
            scan_cnt_reg   <= scan_cnt_next;
            rd_live_reg    <= rd_live_next;
            sub_valid_reg  <= sub_valid_next;
            sub_acked_reg  <= sub_acked_next;
            req_valid_reg  <= req_valid_next;
            expired_reg    <= expired_next;
            s_found_reg    <= s_found_next;
            fs_found_reg   <= fs_found_next;
            r_found_reg    <= r_found_next;
            fr_found_reg   <= fr_found_next;
            best_found_reg <= best_found_next;
            sweep_more_reg <= sweep_more_next;
            any_reg        <= any_next;
            all_reg        <= all_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        rd_idx_reg     <= scan_cnt_reg[IW-1:0];
        s_idx_reg      <= s_idx_next;
        s_owner_reg    <= s_owner_next;
        fs_idx_reg     <= fs_idx_next;
        r_idx_reg      <= r_idx_next;
        fr_idx_reg     <= fr_idx_next;
        slot_reg       <= slot_next;
        best_idx_reg   <= best_idx_next;
        best_ident_reg <= best_ident_next;
        res_status_reg <= res_status_next;
        res_rid_reg    <= res_rid_next;
        res_fin_reg    <= res_fin_next;
        res_last_reg   <= res_last_next;
        if (push)
        begin
            out_status_reg <= res_status_reg;
            out_rid_reg    <= res_rid_reg;
            out_fin_reg    <= res_fin_reg;
            out_last_reg   <= res_last_reg;
        end
    end

    // Sub table memory
    always_ff @(posedge clk)
    begin
        if (sub_we)
        begin
            sub_ident_mem[sub_waddr] <= cmd_reg.sub_id;
            sub_owner_mem[sub_waddr] <= sub_wowner;
        end
        sub_ident_rd_reg <= sub_ident_mem[scan_cnt_reg[SW-1:0]];
        sub_owner_rd_reg <= sub_owner_mem[scan_cnt_reg[SW-1:0]];
    end

    // Request table memory
    always_ff @(posedge clk)
    begin
        if (req_we)
        begin
            req_ident_mem[req_waddr] <= cmd_reg.req_id;
            req_code_mem[req_waddr]  <= cmd_reg.opcode;
            req_start_mem[req_waddr] <= cmd_reg.now;
        end
        req_ident_rd_reg <= req_ident_mem[req_raddr];
        req_start_rd_reg <= req_start_mem[req_raddr];
    end

endmodule
`default_nettype wire

FILE: tb/split_request_ack_tracker_top_tb.sv
`default_nettype none
module split_request_ack_tracker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] request_id;
        logic        finished;
        logic        last;
    } tracker_result_t;

    // Tracks the expected table contents and the results still owed by the block
    class ack_tracker_scoreboard;
        bit          slot_used[srat_pkg::MAX_REQUESTS];
        bit [31:0]   slot_ident[srat_pkg::MAX_REQUESTS];
        bit [31:0]   slot_start[srat_pkg::MAX_REQUESTS];
        bit          sub_used[srat_pkg::MAX_SUBS];
        bit [31:0]   sub_ident[srat_pkg::MAX_SUBS];
        int          sub_owner[srat_pkg::MAX_SUBS];
        bit          sub_acked[srat_pkg::MAX_SUBS];
        bit [15:0]   timeout_sec;
        tracker_result_t expected_results[$];
        int          errors;

        function new();
            timeout_sec = srat_pkg::TIMEOUT_RESET;
            errors = 0;
            foreach (slot_used[i]) slot_used[i] = 0;
            foreach (sub_used[i])
            begin
                sub_used[i] = 0;
                sub_acked[i] = 0;
            end
        endfunction

        function void push(logic [1:0] st, logic [31:0] rid, logic fin, logic lst);
            tracker_result_t e;
            e.status = st;
            e.request_id = rid;
            e.finished = fin;
            e.last = lst;
            expected_results.push_back(e);
        endfunction

        function int find_slot(bit [31:0] id);
            for (int i = 0; i < srat_pkg::MAX_REQUESTS; i++)
                if (slot_used[i] && slot_ident[i] == id) return i;
            return -1;
        endfunction

        function int find_sub(bit [31:0] id);
            for (int i = 0; i < srat_pkg::MAX_SUBS; i++)
                if (sub_used[i] && sub_ident[i] == id) return i;
            return -1;
        endfunction

        function int free_slot();
            for (int i = 0; i < srat_pkg::MAX_REQUESTS; i++)
                if (!slot_used[i]) return i;
            return -1;
        endfunction

        function int free_sub();
            for (int i = 0; i < srat_pkg::MAX_SUBS; i++)
                if (!sub_used[i]) return i;
            return -1;
        endfunction

        function void drop_slot(int r);
            slot_used[r] = 0;
            for (int i = 0; i < srat_pkg::MAX_SUBS; i++)
                if (sub_used[i] && sub_owner[i] == r)
                begin
                    sub_used[i] = 0;
                    sub_acked[i] = 0;
                end
        endfunction

        function bit owner_done(int r);
            bit any;
            any = 0;
            for (int i = 0; i < srat_pkg::MAX_SUBS; i++)
                if (sub_used[i] && sub_owner[i] == r)
                begin
                    any = 1;
                    if (!sub_acked[i]) return 0;
                end
            return any;
        endfunction

        // Apply one accepted request and queue the results it owes
        function void note_request(logic [2:0] mode, logic [31:0] rid, logic [31:0] sid,
                                   logic [31:0] code, logic [31:0] now_s);
            int r;
            int s;
            int n;
            int best;
            bit expired[srat_pkg::MAX_REQUESTS];
            case (mode) inside
                srat_pkg::MODE_REGISTER:
                begin
                    r = find_slot(rid);
                    s = find_sub(sid);
                    if (r < 0)
                    begin
                        r = free_slot();
                        if (r < 0)
                        begin
                            push(srat_pkg::STATUS_FULL, 0, 0, 1);
                            return;
                        end
                        if (s < 0)
                        begin
                            s = free_sub();
                            if (s < 0)
                            begin
                                push(srat_pkg::STATUS_FULL, 0, 0, 1);
                                return;
                            end
                        end
                        slot_used[r] = 1;
                        slot_ident[r] = rid;
                        slot_start[r] = now_s;
                    end
                    else if (s < 0)
                    begin
                        s = free_sub();
                        if (s < 0)
                        begin
                            push(srat_pkg::STATUS_FULL, 0, 0, 1);
                            return;
                        end
                    end
                    sub_used[s] = 1;
                    sub_ident[s] = sid;
                    sub_owner[s] = r;
                    sub_acked[s] = 0;
                    push(srat_pkg::STATUS_OK, rid, 0, 1);
                end
                srat_pkg::MODE_ACK:
                begin
                    s = find_sub(sid);
                    if (s < 0 || !slot_used[sub_owner[s]])
                        push(srat_pkg::STATUS_MISS, 0, 0, 1);
                    else
                    begin
                        sub_acked[s] = 1;
                        r = sub_owner[s];
                        push(srat_pkg::STATUS_OK, slot_ident[r], owner_done(r), 1);
                    end
                end
                srat_pkg::MODE_DEL_REQ:
                begin
                    r = find_slot(rid);
                    if (r < 0)
                        push(srat_pkg::STATUS_MISS, 0, 0, 1);
                    else
                    begin
                        drop_slot(r);
                        push(srat_pkg::STATUS_OK, rid, 0, 1);
                    end
                end
                srat_pkg::MODE_DEL_SUB, srat_pkg::MODE_LOOKUP:
                begin
                    s = find_sub(sid);
                    if (s < 0 || !slot_used[sub_owner[s]])
                        push(srat_pkg::STATUS_MISS, 0, 0, 1);
                    else
                    begin
                        r = sub_owner[s];
                        push(srat_pkg::STATUS_OK, slot_ident[r], 0, 1);
                        if (mode == srat_pkg::MODE_DEL_SUB) drop_slot(r);
                    end
                end
                srat_pkg::MODE_SWEEP:
                begin
                    n = 0;
                    for (int i = 0; i < srat_pkg::MAX_REQUESTS; i++)
                        expired[i] = slot_used[i] &&
                                     ((now_s - slot_start[i]) > {16'd0, timeout_sec});
                    // Remove expired requests in ascending id order
                    forever
                    begin
                        best = -1;
                        for (int i = 0; i < srat_pkg::MAX_REQUESTS; i++)
                            if (expired[i] && (best < 0 || slot_ident[i] < slot_ident[best]))
                                best = i;
                        if (best < 0) break;
                        expired[best] = 0;
                        push(srat_pkg::STATUS_OK, slot_ident[best], 0, 0);
                        drop_slot(best);
                        n++;
                    end
                    if (n == 0)
                        push(srat_pkg::STATUS_MISS, 0, 0, 1);
                    else
                        expected_results[expected_results.size()-1].last = 1;
                end
                default: push(srat_pkg::STATUS_MISS, 0, 0, 1);
            endcase
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(logic [1:0] st, logic [31:0] rid, logic fin, logic lst);
            tracker_result_t e;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d request_id=%h finished=%0d last=%0d",
                         $time, st, rid, fin, lst);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (st !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (rid !== e.request_id)
            begin
                $display("%0t: request_id expected %h actual %h", $time, e.request_id, rid);
                errors++;
            end
            if (fin !== e.finished)
            begin
                $display("%0t: finished expected %0d actual %0d", $time, e.finished, fin);
                errors++;
            end
            if (lst !== e.last)
            begin
                $display("%0t: last expected %0d actual %0d", $time, e.last, lst);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    srat_in_if  in_ch();
    srat_out_if out_ch();

    split_request_ack_tracker_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ack_tracker_scoreboard sb = new();

    int          burst_left;
    int unsigned clock_count;
    bit [31:0]   req_pool[20];
    bit [31:0]   sub_pool[72];
    bit [31:0]   clock_now;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        out_ch.ready = 1'b0;
        clock_count = 0;
    end

    // Stall the result side on a rotating pattern: always, random, mostly and rarely ready
    always @(posedge clk)
    begin
        clock_count <= clock_count + 1;
        case ((clock_count / 300) % 4)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 1) == 1);
            2: out_ch.ready <= (clock_count % 4 != 0);
            default: out_ch.ready <= ($urandom_range(0, 9) < 2);
        endcase
    end

    // Check every accepted result
    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.status, out_ch.request_id, out_ch.finished, out_ch.last);

    task automatic send_request(logic [2:0] mode, logic [31:0] rid, logic [31:0] sid,
                                logic [31:0] code, logic [31:0] now_s);
        // Insert a gap between bursts
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 30 : $urandom_range(1, 10);
        end
        in_ch.valid  <= 1'b1;
        in_ch.mode   <= mode;
        in_ch.req_id <= rid;
        in_ch.sub_id <= sid;
        in_ch.opcode <= code;
        in_ch.now    <= now_s;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_request(mode, rid, sid, code, now_s);
        burst_left--;
    endtask

    // Hold until every owed result has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_timeout(logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {srat_pkg::REG_TIMEOUT, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.timeout_sec = value;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_req();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return req_pool[$urandom_range(0, 19)];
    endfunction

    function automatic logic [31:0] pick_sub();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return sub_pool[$urandom_range(0, 71)];
    endfunction

    task automatic random_requests(int count);
        int w;
        logic [2:0] mode;
        logic [31:0] stamp;
        for (int k = 0; k < count; k++)
        begin
            w = $urandom_range(0, 99);
            if (w < 40)      mode = srat_pkg::MODE_REGISTER;
            else if (w < 62) mode = srat_pkg::MODE_ACK;
            else if (w < 70) mode = srat_pkg::MODE_DEL_REQ;
            else if (w < 77) mode = srat_pkg::MODE_DEL_SUB;
            else if (w < 87) mode = srat_pkg::MODE_LOOKUP;
            else if (w < 97) mode = srat_pkg::MODE_SWEEP;
            else             mode = $urandom_range(6, 7);
            clock_now += $urandom_range(0, 9);
            stamp = ($urandom_range(0, 19) == 0) ? $urandom : clock_now;
            send_request(mode, pick_req(), pick_sub(), $urandom, stamp);
            // Pause once until the block has caught up
            if (k == count / 2 && count > 40) drain();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.mode   = srat_pkg::MODE_REGISTER;
        in_ch.req_id = '0;
        in_ch.sub_id = '0;
        in_ch.opcode = '0;
        in_ch.now    = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        burst_left   = 0;
        clock_now    = 32'd1000;
        req_pool[0] = 32'h0;
        req_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 20; i++) req_pool[i] = $urandom;
        sub_pool[0] = 32'h0;
        sub_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 72; i++) sub_pool[i] = $urandom;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every operation, re-registration, wraparound age
        send_request(srat_pkg::MODE_REGISTER, 32'h0, 32'h0, 32'h0, 32'h0);
        send_request(srat_pkg::MODE_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF);
        send_request(srat_pkg::MODE_REGISTER, 32'hFFFF_FFFF, 32'h1, 32'h1234_5678, 32'h10);
        send_request(srat_pkg::MODE_REGISTER, 32'h0, 32'h1, 32'h0, 32'h0);
        send_request(srat_pkg::MODE_ACK, 32'h0, 32'h0, 32'h0, 32'h0);
        send_request(srat_pkg::MODE_ACK, 32'h0, 32'h1, 32'h0, 32'h0);
        send_request(srat_pkg::MODE_ACK, 32'h0, 32'h7777, 32'h0, 32'h0);
        send_request(srat_pkg::MODE_LOOKUP, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_request(srat_pkg::MODE_LOOKUP, 32'h0, 32'h5555, 32'h0, 32'h0);
        send_request(srat_pkg::MODE_DEL_SUB, 32'h0, 32'h1, 32'h0, 32'h0);
        send_request(srat_pkg::MODE_DEL_SUB, 32'h0, 32'h1, 32'h0, 32'h0);
        send_request(srat_pkg::MODE_DEL_REQ, 32'h1234, 32'h0, 32'h0, 32'h0);
        send_request(srat_pkg::MODE_DEL_REQ, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
        send_request(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(3'd7, 32'h0, 32'h0, 32'h0, 32'h0);
        send_request(srat_pkg::MODE_SWEEP, 32'h0, 32'h0, 32'h0, 32'h5);
        send_request(srat_pkg::MODE_REGISTER, 32'h5, 32'h50, 32'hA5A5_A5A5, 32'hFFFF_FFF0);
        send_request(srat_pkg::MODE_REGISTER, 32'h3, 32'h30, 32'h5A5A_5A5A, 32'hFFFF_FFF0);
        send_request(srat_pkg::MODE_REGISTER, 32'h9, 32'h90, 32'h1, 32'h8);
        send_request(srat_pkg::MODE_SWEEP, 32'h0, 32'h0, 32'h0, 32'h0000_000A);
        send_request(srat_pkg::MODE_SWEEP, 32'h0, 32'h0, 32'h0, 32'h0000_0100);

        // Random phases under several timeouts, extremes included
        random_requests(50);
        drain();
        write_timeout(16'd0);
        random_requests(50);
        drain();
        write_timeout(16'd35);
        random_requests(60);
        drain();
        write_timeout(16'hFFFF);
        random_requests(40);
        drain();
        write_timeout(16'd8);
        random_requests(30);
        drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
